/* rtl/tss_pkg.sv */
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants of the thread slot scheduler
// Command kinds, result codes, slot states and the control/status structs.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int unsigned TssMaxThreads = 16;
  localparam logic [4:0]  CntMax        = 5'd31;

  typedef enum logic [2:0] {
    KIND_INIT       = 3'd0,
    KIND_SPAWN      = 3'd1,
    KIND_YIELD      = 3'd2,
    KIND_EXIT       = 3'd3,
    KIND_JOIN       = 3'd4,
    KIND_JOIN_RETRY = 3'd5
  } tss_kind_e;

  typedef enum logic [2:0] {
    RES_OK            = 3'd0,
    RES_NONE_RUNNABLE = 3'd1,
    RES_BAD_TARGET    = 3'd2,
    RES_DEADLOCK      = 3'd3,
    RES_WAIT          = 3'd4,
    RES_FULL          = 3'd5,
    RES_ALL_DONE      = 3'd6
  } tss_res_e;

  typedef enum logic [1:0] {
    SLOT_RUN    = 2'd0,
    SLOT_EXITED = 2'd1,
    SLOT_JOINED = 2'd2
  } tss_slot_e;

  typedef struct packed {
    logic capture;
    logic init;
    logic scan_spawn;
    logic scan_yield;
    logic scan_run;
    logic scan_hit;
    logic scan_miss;
    logic exit_last;
    logic exit_mark;
    logic join_start;
    logic join_bad;
    logic join_take;
    logic join_dead;
    logic join_wait;
    logic nop;
    logic out_load;
  } tss_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       exit_last;
    logic       tid_bad;
    logic [1:0] tgt_state;
    logic       dead;
    logic       scan_hit;
    logic       scan_done;
    logic       out_free;
  } tss_sts_t;

  function automatic logic [4:0] cnt_inc(input logic [4:0] v);
    return (v < CntMax) ? v + 5'd1 : v;
  endfunction

  function automatic logic [4:0] cnt_dec(input logic [4:0] v);
    return (v != 5'd0) ? v - 5'd1 : v;
  endfunction

endpackage

/* rtl/tss_if.sv */
// ----------------------------------------------------------------------------
// tss_if: command and response channels of the thread slot scheduler
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface tss_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [4:0]  target_tid;
  logic signed [31:0] exit_value;

  modport source (output valid, kind, target_tid, exit_value, input ready);
  modport sink   (input valid, kind, target_tid, exit_value, output ready);
endinterface

interface tss_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         result_code;
  logic [3:0]         thread_id;
  logic signed [31:0] joined_value;

  modport source (output valid, result_code, thread_id, joined_value, input ready);
  modport sink   (input valid, result_code, thread_id, joined_value, output ready);
endinterface

/* rtl/tss_ctrl.sv */
// ----------------------------------------------------------------------------
// tss_ctrl: command sequencer of the thread slot scheduler
// Decodes each command and steps the datapath through lookup, scan and reply.
// ----------------------------------------------------------------------------
module tss_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tss_pkg::tss_sts_t sts_i,
  output tss_pkg::tss_cmd_t cmd_o
);
  import tss_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_JOIN   = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_RESP   = 5'b10000
  } tss_state_e;

  tss_state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.kind)
          KIND_INIT: begin
            cmd_o.init = 1'b1;
            state_d    = ST_RESP;
          end
          KIND_SPAWN: begin
            cmd_o.scan_spawn = 1'b1;
            state_d          = ST_SCAN;
          end
          KIND_YIELD: begin
            cmd_o.scan_yield = 1'b1;
            state_d          = ST_SCAN;
          end
          KIND_EXIT: begin
            if (sts_i.exit_last) begin
              cmd_o.exit_last = 1'b1;
              state_d         = ST_RESP;
            end else begin
              cmd_o.exit_mark  = 1'b1;
              cmd_o.scan_yield = 1'b1;
              state_d          = ST_SCAN;
            end
          end
          KIND_JOIN, KIND_JOIN_RETRY: begin
            cmd_o.join_start = 1'b1;
            state_d          = ST_JOIN;
          end
          default: begin
            cmd_o.nop = 1'b1;
            state_d   = ST_RESP;
          end
        endcase
      end
      ST_JOIN: begin
        if (sts_i.tid_bad || (sts_i.tgt_state == SLOT_JOINED)) begin
          cmd_o.join_bad = 1'b1;
          state_d        = ST_RESP;
        end else if (sts_i.tgt_state != SLOT_RUN) begin
          cmd_o.join_take = 1'b1;
          state_d         = ST_RESP;
        end else if (sts_i.dead) begin
          cmd_o.join_dead = 1'b1;
          state_d         = ST_RESP;
        end else begin
          cmd_o.join_wait  = 1'b1;
          cmd_o.scan_yield = 1'b1;
          state_d          = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_hit) begin
          cmd_o.scan_hit = 1'b1;
          state_d        = ST_RESP;
        end else if (sts_i.scan_done) begin
          cmd_o.scan_miss = 1'b1;
          state_d         = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_DECODE))
    else $error("accepted command not decoded");

  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && !sts_i.out_free) |=> (state_q == ST_RESP))
    else $error("reply dropped while output register busy");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.init, cmd_o.exit_last, cmd_o.join_bad, cmd_o.join_take,
              cmd_o.join_dead, cmd_o.nop, cmd_o.scan_hit, cmd_o.scan_miss}))
    else $error("more than one result source in a cycle");
`endif

endmodule

/* rtl/tss_dp.sv */
// ----------------------------------------------------------------------------
// tss_dp: datapath of the thread slot scheduler
// Slot state and exit value memories, counters, round-robin scan, reply register.
// ----------------------------------------------------------------------------
module tss_dp #(
  parameter int unsigned MAX_THREADS = tss_pkg::TssMaxThreads
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tss_pkg::tss_cmd_t  cmd_i,
  output tss_pkg::tss_sts_t  sts_o,
  input  logic [2:0]         kind_i,
  input  logic signed [4:0]  target_tid_i,
  input  logic signed [31:0] exit_value_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [2:0]         result_code_o,
  output logic [3:0]         thread_id_o,
  output logic signed [31:0] joined_value_o
);
  import tss_pkg::*;

  localparam int unsigned AW = $clog2(MAX_THREADS);
  localparam int unsigned LW = $clog2(MAX_THREADS + 1);
  localparam int unsigned CW = (LW > 5) ? LW : 5;

  // command payload
  logic [2:0]         kind_q;
  logic signed [4:0]  tid_q;
  logic signed [31:0] xval_q;

  // scheduler state
  logic [AW-1:0] active_q, active_d;
  logic [LW-1:0] limit_q, limit_d;
  logic [4:0]    running_q, running_d;
  logic [4:0]    joining_q, joining_d;

  logic [1:0]             st_mem  [MAX_THREADS];
  logic [31:0]            val_mem [MAX_THREADS];
  logic [MAX_THREADS-1:0] st_vld_q;

  // scan
  logic [AW-1:0] scan_idx_q, scan_idx_d;
  logic [LW-1:0] scan_left_q, scan_left_d;
  logic          scan_spawn_q, scan_spawn_d;
  logic          rd_vld_q;
  logic [AW-1:0] rd_tag_q;
  logic [1:0]    st_rd_q;
  logic          st_rd_vld_q;
  logic [31:0]   val_rd_q;

  // result
  tss_res_e      code_q, code_d;
  logic [AW-1:0] tout_q, tout_d;
  logic [31:0]   jval_q, jval_d;

  logic               out_valid_q;
  logic [2:0]         out_code_q;
  logic [3:0]         out_tid_q;
  logic signed [31:0] out_jval_q;

  logic [CW-1:0] tgt_ext;
  logic [AW-1:0] tgt_addr;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] act_inc;
  logic [LW-1:0] idx_inc;
  logic [AW-1:0] yield_start;
  logic [AW-1:0] scan_idx_nxt;
  logic [1:0]    rd_state;
  logic          scan_match;
  logic          limit_open;
  logic          st_we;
  logic [AW-1:0] st_waddr;
  logic [1:0]    st_wdata;
  logic [CW-1:0] tout_ext;

  assign tgt_ext      = CW'(tid_q[3:0]);
  assign tgt_addr     = tgt_ext[AW-1:0];
  assign rd_addr      = cmd_i.scan_run ? scan_idx_q : tgt_addr;
  assign act_inc      = LW'(active_q) + LW'(1);
  assign yield_start  = (act_inc == limit_q) ? '0 : act_inc[AW-1:0];
  assign idx_inc      = LW'(scan_idx_q) + LW'(1);
  assign scan_idx_nxt = (idx_inc == limit_q) ? '0 : idx_inc[AW-1:0];
  assign rd_state     = st_rd_vld_q ? st_rd_q : SLOT_RUN;
  assign scan_match   = rd_vld_q &&
                        (scan_spawn_q ? (rd_state == SLOT_JOINED) : (rd_state == SLOT_RUN));
  assign limit_open   = (limit_q < LW'(MAX_THREADS));

  assign sts_o.kind      = kind_q;
  assign sts_o.exit_last = (running_q <= 5'd1);
  assign sts_o.tid_bad   = tid_q[4] || (tgt_ext >= CW'(limit_q));
  assign sts_o.tgt_state = rd_state;
  assign sts_o.dead      = (kind_q == KIND_JOIN) && (joining_q == running_q);
  assign sts_o.scan_hit  = scan_match;
  assign sts_o.scan_done = !rd_vld_q && (scan_left_q == '0);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // slot state write port
  always_comb begin
    st_we    = 1'b0;
    st_waddr = active_q;
    st_wdata = SLOT_RUN;
    if (cmd_i.exit_mark) begin
      st_we    = 1'b1;
      st_waddr = active_q;
      st_wdata = SLOT_EXITED;
    end else if (cmd_i.join_take) begin
      st_we    = 1'b1;
      st_waddr = tgt_addr;
      st_wdata = SLOT_JOINED;
    end else if (cmd_i.scan_hit && scan_spawn_q) begin
      st_we    = 1'b1;
      st_waddr = rd_tag_q;
    end else if (cmd_i.scan_miss && scan_spawn_q && limit_open) begin
      st_we    = 1'b1;
      st_waddr = limit_q[AW-1:0];
    end
  end

  always_comb begin
    active_d     = active_q;
    limit_d      = limit_q;
    running_d    = running_q;
    joining_d    = joining_q;
    scan_idx_d   = scan_idx_q;
    scan_left_d  = scan_left_q;
    scan_spawn_d = scan_spawn_q;
    code_d       = code_q;
    tout_d       = tout_q;
    jval_d       = jval_q;

    if (cmd_i.capture) begin
      code_d = RES_OK;
      jval_d = '0;
    end
    if (cmd_i.init) begin
      active_d  = '0;
      limit_d   = LW'(1);
      running_d = 5'd1;
      joining_d = 5'd0;
      tout_d    = '0;
    end
    if (cmd_i.nop) begin
      tout_d = active_q;
    end
    if (cmd_i.scan_spawn) begin
      scan_idx_d   = '0;
      scan_left_d  = limit_q;
      scan_spawn_d = 1'b1;
    end
    if (cmd_i.scan_yield) begin
      scan_idx_d   = yield_start;
      scan_left_d  = limit_q;
      scan_spawn_d = 1'b0;
    end
    if (cmd_i.scan_run && (scan_left_q != '0)) begin
      scan_idx_d  = scan_idx_nxt;
      scan_left_d = scan_left_q - LW'(1);
    end
    if (cmd_i.exit_last) begin
      running_d = cnt_dec(running_q);
      code_d    = RES_ALL_DONE;
      tout_d    = active_q;
    end
    if (cmd_i.exit_mark) begin
      running_d = cnt_dec(running_q);
    end
    if (cmd_i.join_start && (kind_q == KIND_JOIN)) begin
      joining_d = cnt_inc(joining_q);
    end
    if (cmd_i.join_bad) begin
      code_d    = RES_BAD_TARGET;
      joining_d = cnt_dec(joining_q);
      tout_d    = active_q;
    end
    if (cmd_i.join_take) begin
      jval_d    = val_rd_q;
      joining_d = cnt_dec(joining_q);
      tout_d    = active_q;
    end
    if (cmd_i.join_dead) begin
      code_d    = RES_DEADLOCK;
      joining_d = cnt_dec(joining_q);
      tout_d    = active_q;
    end
    if (cmd_i.join_wait) begin
      code_d = RES_WAIT;
    end
    if (cmd_i.scan_hit) begin
      tout_d = rd_tag_q;
      if (scan_spawn_q) begin
        running_d = cnt_inc(running_q);
      end else begin
        active_d = rd_tag_q;
      end
    end
    if (cmd_i.scan_miss) begin
      if (scan_spawn_q) begin
        if (limit_open) begin
          tout_d    = limit_q[AW-1:0];
          limit_d   = limit_q + LW'(1);
          running_d = cnt_inc(running_q);
        end else begin
          code_d = RES_FULL;
          tout_d = '0;
        end
      end else begin
        tout_d = active_q;
        if (code_q == RES_OK) begin
          code_d = RES_NONE_RUNNABLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= '0;
      limit_q      <= LW'(1);
      running_q    <= 5'd1;
      joining_q    <= 5'd0;
      scan_left_q  <= '0;
      scan_spawn_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      st_vld_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      active_q     <= active_d;
      limit_q      <= limit_d;
      running_q    <= running_d;
      joining_q    <= joining_d;
      scan_left_q  <= scan_left_d;
      scan_spawn_q <= scan_spawn_d;
      rd_vld_q     <= cmd_i.scan_run && (scan_left_q != '0);
      if (cmd_i.init) begin
        st_vld_q <= '0;
      end else if (st_we) begin
        st_vld_q[st_waddr] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (cmd_i.exit_mark) begin
      val_mem[active_q] <= xval_q;
    end
    st_rd_q     <= st_mem[rd_addr];
    val_rd_q    <= val_mem[rd_addr];
    st_rd_vld_q <= st_vld_q[rd_addr];
    rd_tag_q    <= rd_addr;
  end

  assign tout_ext = CW'(tout_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q <= kind_i;
      tid_q  <= target_tid_i;
      xval_q <= exit_value_i;
    end
    scan_idx_q <= scan_idx_d;
    code_q     <= code_d;
    tout_q     <= tout_d;
    jval_q     <= jval_d;
    if (cmd_i.out_load) begin
      out_code_q <= code_q;
      out_tid_q  <= tout_ext[3:0];
      out_jval_q <= jval_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_code_o  = out_code_q;
  assign thread_id_o    = out_tid_q;
  assign joined_value_o = out_jval_q;

`ifndef SYNTHESIS
  a_active_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LW'(active_q) < limit_q)
    else $error("active slot beyond slot limit");

  a_limit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (limit_q != '0) && (limit_q <= LW'(MAX_THREADS)))
    else $error("slot limit out of range");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> ((LW'(rd_tag_q) < limit_q) && (scan_left_q < limit_q)))
    else $error("scan read outside the slots in use");
`endif

endmodule

/* rtl/thread_slot_scheduler.sv */
// ----------------------------------------------------------------------------
// thread_slot_scheduler: round-robin thread slot table with spawn/yield/exit/join
// Init, unused kinds, last exit: decode, then reply. Join without wait: decode,
// join check, reply. Spawn, yield, exit: decode, scan of the slots in use, reply;
// join wait: decode, join check, scan, reply; one slot state read per scan cycle.
// One command at a time, accepted after the reply is loaded; hold while it waits.
// Async active-low reset equals an init command.
// ----------------------------------------------------------------------------
module thread_slot_scheduler #(
  parameter int unsigned MAX_THREADS = tss_pkg::TssMaxThreads
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tss_cmd_if.sink    cmd_i,
  tss_rsp_if.source  rsp_o
);
  import tss_pkg::*;

  tss_cmd_t cmd;
  tss_sts_t sts;

  tss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tss_dp #(
    .MAX_THREADS (MAX_THREADS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (cmd_i.kind),
    .target_tid_i   (cmd_i.target_tid),
    .exit_value_i   (cmd_i.exit_value),
    .out_ready_i    (rsp_o.ready),
    .out_valid_o    (rsp_o.valid),
    .result_code_o  (rsp_o.result_code),
    .thread_id_o    (rsp_o.thread_id),
    .joined_value_o (rsp_o.joined_value)
  );

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: thread slot scheduler check against a built-in slot table model
// Drives init/spawn/yield/exit/join/join-retry commands, first a directed
// sequence, then random command streams in three idling profiles, and
// compares every response transfer with the model's prediction.
// ----------------------------------------------------------------------------
module testbench;
  import tss_pkg::*;

  localparam int unsigned NSLOTS         = TssMaxThreads;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES    = 40;
  localparam int unsigned REPORT_MAX     = 10;
  localparam logic [2:0]  KIND_SPARE6    = 3'd6;
  localparam logic [2:0]  KIND_SPARE7    = 3'd7;

  typedef struct {
    logic [2:0]         kind;
    logic signed [4:0]  tid;
    logic signed [31:0] xval;
    bit                 hold;
    int unsigned        phase;
  } sched_cmd_t;

  typedef struct {
    tss_res_e           code;
    logic [3:0]         tid;
    logic signed [31:0] jval;
  } sched_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tss_cmd_if cmd ();
  tss_rsp_if rsp ();

  thread_slot_scheduler uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  always #2 clk_i = ~clk_i;

  int unsigned tx_idle_pct [3] = '{27, 86, 0};
  int unsigned rx_idle_pct [3] = '{86, 27, 0};

  sched_cmd_t  pend_q [$];
  sched_rsp_t  rsp_exp_q [$];
  int unsigned sent_cnt     = 0;
  int unsigned recv_cnt     = 0;
  int unsigned idle_phase   = 0;
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;

  // slot table model
  logic [1:0]  slot_st [NSLOTS];
  logic [31:0] slot_val [NSLOTS];
  logic [3:0]  cur_slot;
  logic [4:0]  n_slots;
  logic [4:0]  n_running;
  logic [4:0]  n_joining;

  function automatic logic [4:0] sat_up(logic [4:0] v);
    return (v != 5'd31) ? v + 5'd1 : v;
  endfunction

  function automatic logic [4:0] sat_down(logic [4:0] v);
    return (v != 5'd0) ? v - 5'd1 : v;
  endfunction

  function automatic void sched_clear();
    for (int i = 0; i < NSLOTS; i++) slot_st[i] = SLOT_RUN;
    cur_slot  = '0;
    n_slots   = 5'd1;
    n_running = 5'd1;
    n_joining = 5'd0;
  endfunction

  function automatic bit rr_advance();
    int unsigned lim;
    int unsigned k;
    int unsigned t;
    lim = n_slots;
    if (lim == 0 || lim > NSLOTS) return 1'b0;
    for (k = 1; k <= lim; k++) begin
      t = (cur_slot + k) % lim;
      if (slot_st[t] == SLOT_RUN) begin
        cur_slot = 4'(t);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic sched_rsp_t sched_predict(sched_cmd_t c);
    sched_rsp_t  r;
    int unsigned pos;
    int          t;
    bit          found;
    r.code = RES_OK;
    r.tid  = '0;
    r.jval = '0;
    pos    = 0;
    found  = 1'b0;
    t      = c.tid;
    case (c.kind)
      KIND_INIT: begin
        sched_clear();
      end
      KIND_SPAWN: begin
        for (int i = 0; i < n_slots && i < NSLOTS; i++) begin
          if (!found && slot_st[i] == SLOT_JOINED) begin
            found = 1'b1;
            pos   = i;
          end
        end
        if (!found) begin
          if (n_slots < NSLOTS) begin
            pos     = n_slots;
            n_slots = n_slots + 5'd1;
          end else begin
            r.code = RES_FULL;
          end
        end
        if (r.code == RES_OK) begin
          slot_st[pos] = SLOT_RUN;
          n_running    = sat_up(n_running);
          r.tid        = 4'(pos);
        end
      end
      KIND_YIELD: begin
        r.code = rr_advance() ? RES_OK : RES_NONE_RUNNABLE;
        r.tid  = cur_slot;
      end
      KIND_EXIT: begin
        n_running = sat_down(n_running);
        if (n_running == 5'd0) begin
          r.code = RES_ALL_DONE;
        end else begin
          slot_val[cur_slot] = c.xval;
          slot_st[cur_slot]  = SLOT_EXITED;
          r.code = rr_advance() ? RES_OK : RES_NONE_RUNNABLE;
        end
        r.tid = cur_slot;
      end
      KIND_JOIN, KIND_JOIN_RETRY: begin
        if (c.kind == KIND_JOIN) n_joining = sat_up(n_joining);
        if (t < 0 || t >= int'(n_slots) || t >= int'(NSLOTS) || slot_st[t] == SLOT_JOINED)
        begin
          r.code    = RES_BAD_TARGET;
          n_joining = sat_down(n_joining);
        end else if (slot_st[t] != SLOT_RUN) begin
          slot_st[t] = SLOT_JOINED;
          r.jval     = slot_val[t];
          n_joining  = sat_down(n_joining);
        end else if (c.kind == KIND_JOIN && n_joining == n_running) begin
          r.code    = RES_DEADLOCK;
          n_joining = sat_down(n_joining);
        end else begin
          r.code = RES_WAIT;
          void'(rr_advance());
        end
        r.tid = cur_slot;
      end
      default: begin
        r.tid = cur_slot;
      end
    endcase
    return r;
  endfunction

  task automatic add_cmd(logic [2:0] k, logic signed [4:0] t, logic signed [31:0] v,
                         bit hold, int unsigned ph);
    sched_cmd_t c;
    c.kind  = k;
    c.tid   = t;
    c.xval  = v;
    c.hold  = hold;
    c.phase = ph;
    pend_q.push_back(c);
  endtask

  task automatic gen_random(int unsigned n, int unsigned ph);
    int unsigned       made;
    int unsigned       sel;
    logic signed [4:0] t;
    logic signed [31:0] v;
    made = 0;
    // wait for an empty pipeline before the phase starts
    add_cmd(KIND_YIELD, '0, '0, 1'b1, ph);
    while (made < n) begin
      sel = $urandom_range(0, 9);
      if (sel == 0) t = 5'($urandom_range(16, 31));
      else if (sel < 7) t = 5'($urandom_range(0, 5));
      else t = 5'($urandom_range(0, 15));
      case ($urandom_range(0, 9))
        0: v = 32'sh8000_0000;
        1: v = 32'sh7fff_ffff;
        2: v = -32'sd1;
        default: v = $urandom();
      endcase
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 59) == 0) begin
        // fill the table and run into full
        repeat (17) add_cmd(KIND_SPAWN, t, $urandom(), 1'b0, ph);
        made += 17;
      end else if (sel < 3) begin
        add_cmd(KIND_INIT, t, v, 1'b0, ph);
        made++;
      end else if (sel < 28) begin
        add_cmd(KIND_SPAWN, t, v, 1'b0, ph);
        made++;
      end else if (sel < 40) begin
        add_cmd(KIND_YIELD, t, v, 1'b0, ph);
        made++;
      end else if (sel < 60) begin
        add_cmd(KIND_EXIT, t, v, 1'b0, ph);
        made++;
      end else if (sel < 82) begin
        add_cmd(KIND_JOIN, t, v, 1'b0, ph);
        made++;
      end else if (sel < 97) begin
        add_cmd(KIND_JOIN_RETRY, t, v, 1'b0, ph);
        made++;
      end else begin
        add_cmd(sel[0] ? KIND_SPARE7 : KIND_SPARE6, t, v, 1'b0, ph);
      end
    end
  endtask

  task automatic log_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("MISMATCH: %s", msg);
  endtask

  // driver
  always @(posedge clk_i) begin
    bit         took;
    sched_rsp_t want;
    if (!rst_ni) begin
      cmd.valid <= 1'b0;
    end else begin
      took = cmd.valid && cmd.ready;
      if (took) begin
        want = sched_predict(pend_q.pop_front());
        rsp_exp_q.push_back(want);
        sent_cnt <= sent_cnt + 1;
      end
      if (took || !cmd.valid) begin
        if (pend_q.size() == 0) begin
          cmd.valid <= 1'b0;
        end else if (pend_q[0].hold && (took || sent_cnt != recv_cnt)) begin
          cmd.valid <= 1'b0;
        end else if ($urandom_range(0, 99) < tx_idle_pct[pend_q[0].phase]) begin
          cmd.valid <= 1'b0;
        end else begin
          cmd.valid      <= 1'b1;
          cmd.kind       <= pend_q[0].kind;
          cmd.target_tid <= pend_q[0].tid;
          cmd.exit_value <= pend_q[0].xval;
          idle_phase     <= pend_q[0].phase;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    sched_rsp_t want;
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        recv_cnt <= recv_cnt + 1;
        if (rsp_exp_q.size() == 0) begin
          log_mismatch($sformatf("transfer with nothing expected: code %0d tid %0d val %0d",
                                 rsp.result_code, rsp.thread_id, rsp.joined_value));
        end else begin
          want = rsp_exp_q.pop_front();
          if (rsp.result_code !== want.code || rsp.thread_id !== want.tid ||
              rsp.joined_value !== want.jval) begin
            log_mismatch($sformatf(
              "response %0d: expected code %0d tid %0d val %0d, got code %0d tid %0d val %0d",
              recv_cnt, want.code, want.tid, want.jval,
              rsp.result_code, rsp.thread_id, rsp.joined_value));
          end
        end
      end
      rsp.ready <= ($urandom_range(0, 99) >= rx_idle_pct[idle_phase]);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("thread_slot_scheduler verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cmd.valid      = 1'b0;
    cmd.kind       = KIND_INIT;
    cmd.target_tid = '0;
    cmd.exit_value = '0;
    rsp.ready      = 1'b0;
    sched_clear();

    add_cmd(KIND_INIT,       5'sd0,   32'sd0,         1'b0, 0);
    add_cmd(KIND_SPARE6,     5'sd3,   32'sd5,         1'b0, 0);
    add_cmd(KIND_SPARE7,     -5'sd1,  -32'sd1,        1'b0, 0);
    add_cmd(KIND_YIELD,      5'sd0,   32'sd0,         1'b0, 0);
    add_cmd(KIND_JOIN,       -5'sd16, 32'sd0,         1'b0, 0);
    add_cmd(KIND_JOIN,       5'sd15,  32'sd0,         1'b0, 0);
    add_cmd(KIND_JOIN,       5'sd0,   32'sd0,         1'b0, 0);
    add_cmd(KIND_JOIN_RETRY, 5'sd0,   32'sd0,         1'b0, 0);
    add_cmd(KIND_JOIN_RETRY, -5'sd1,  32'sd0,         1'b0, 0);
    add_cmd(KIND_EXIT,       5'sd0,   32'sh8000_0000, 1'b0, 0);
    add_cmd(KIND_INIT,       5'sd0,   32'sd0,         1'b0, 0);
    add_cmd(KIND_SPAWN,      5'sd0,   32'sd0,         1'b0, 0);
    add_cmd(KIND_EXIT,       5'sd0,   32'sh7fff_ffff, 1'b0, 0);
    add_cmd(KIND_JOIN,       5'sd0,   32'sd0,         1'b0, 0);
    add_cmd(KIND_JOIN,       5'sd0,   32'sd0,         1'b0, 0);
    add_cmd(KIND_SPAWN,      5'sd0,   32'sd0,         1'b0, 0);
    add_cmd(KIND_EXIT,       5'sd0,   -32'sd1,        1'b0, 0);
    add_cmd(KIND_EXIT,       5'sd0,   32'sd0,         1'b0, 0);
    gen_random(300, 0);
    gen_random(300, 1);
    gen_random(300, 2);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pend_q.size() != 0 || rsp_exp_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && rsp_exp_q.size() == 0) begin
      $display("thread_slot_scheduler verification clean");
    end else begin
      $display("thread_slot_scheduler verification failed");
    end
    $finish;
  end

endmodule

/* thread_slot_scheduler.f */
rtl/tss_pkg.sv
rtl/tss_if.sv
rtl/tss_ctrl.sv
rtl/tss_dp.sv
rtl/thread_slot_scheduler.sv
tb/sv/testbench.sv
